/* design/sma_pkg.sv */
// Shared types and constants for the simple moving average block.
// No dependencies.
package sma_pkg;

  localparam int SAMPLE_W = 32;
  localparam int WL_W     = 7;
  localparam logic [WL_W-1:0] WL_RESET = 7'd5;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start_of_series;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average_value;
    logic                       is_average;
  } out_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ACC  = 6'b000010,
    S_NEG  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIX  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

endpackage

/* design/simple_moving_average.sv */
// Simple moving average over signed Q15.16 samples, one result per sample.
// Depends on sma_pkg and sma_ram.
//
// Each sample is stored in a ring RAM of MAX_WINDOW entries. While the sample's
// index in the series is below the window length n, the sample is passed through
// (is_average = 0) and the next sample may follow as soon as the passed sample
// has been transferred out. Otherwise the last n samples are read back one per cycle through the
// RAM's single read port and summed, then the sum is divided by n with one
// quotient bit per cycle; accumulate, sign handling and divide all share one
// adder. in_ready stays low until the result has been transferred out.
// window_length 0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW, and it
// must only be written while the block is idle.
module simple_moving_average #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sma_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sma_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sma_pkg::WL_W-1:0]       cfg_data
);

  localparam int AW  = $clog2(MAX_WINDOW);
  localparam int EW  = $clog2(MAX_WINDOW + 1);
  localparam int SW  = sma_pkg::SAMPLE_W + AW;
  localparam int ADW = SW + 1;
  localparam int DCW = $clog2(SW + 1);

  sma_pkg::state_t state;

  logic [sma_pkg::WL_W-1:0] window_length;
  logic [AW-1:0]            write_pointer;
  logic [EW-1:0]            seen_count;
  logic [AW-1:0]            rd_ptr;
  logic [EW-1:0]            issue_cnt;
  logic                     data_vld;
  logic [SW-1:0]            acc;
  logic [EW-1:0]            rem;
  logic [EW-1:0]            n_q;
  logic                     neg;
  logic [DCW-1:0]           div_cnt;

  logic [EW-1:0]                 eff_len;
  logic [EW-1:0]                 idx;
  logic                          pass;
  logic                          in_xfer;
  logic                          issuing;
  logic [EW:0]                   rem_sh;
  logic [sma_pkg::SAMPLE_W-1:0]  rdata;
  logic [ADW-1:0]                add_a;
  logic [ADW-1:0]                add_b;
  logic                          add_sub;
  logic [ADW-1:0]                add_sum;

  assign in_ready  = (state == sma_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign issuing   = (issue_cnt != n_q);
  assign rem_sh    = {rem, acc[SW-1]};

  always_comb begin
    if (window_length == '0) begin
      eff_len = EW'(1);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      eff_len = EW'(MAX_WINDOW);
    end else begin
      eff_len = EW'(window_length);
    end
  end

  assign idx  = in_data.start_of_series ? '0 : seen_count;
  assign pass = (idx < eff_len);

  sma_ram #(
    .WIDTH(sma_pkg::SAMPLE_W),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (in_xfer),
    .waddr(write_pointer),
    .wdata(in_data.sample),
    .raddr(rd_ptr),
    .rdata(rdata)
  );

  // shared adder: accumulate, negate, trial subtract
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state)
      sma_pkg::S_ACC: begin
        add_a = {acc[SW-1], acc};
        add_b = {{(ADW-sma_pkg::SAMPLE_W){rdata[sma_pkg::SAMPLE_W-1]}}, rdata};
      end
      sma_pkg::S_NEG: begin
        add_b   = {acc[SW-1], acc};
        add_sub = 1'b1;
      end
      sma_pkg::S_DIV: begin
        add_a   = {{(ADW-EW-1){1'b0}}, rem_sh};
        add_b   = {{(ADW-EW){1'b0}}, n_q};
        add_sub = 1'b1;
      end
      sma_pkg::S_FIX: begin
        add_b   = {{(ADW-SW){1'b0}}, acc};
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + ADW'(add_sub);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sma_pkg::S_IDLE;
      out_valid     <= 1'b0;
      window_length <= sma_pkg::WL_RESET;
      write_pointer <= '0;
      seen_count    <= '0;
      issue_cnt     <= '0;
      data_vld      <= 1'b0;
      div_cnt       <= '0;
    end else begin
      if (cfg_valid) begin
        window_length <= cfg_data;
      end
      case (state)
        sma_pkg::S_IDLE: begin
          if (in_xfer) begin
            write_pointer <= (write_pointer == AW'(MAX_WINDOW - 1)) ? '0
                                                                    : write_pointer + 1'b1;
            seen_count    <= (idx == EW'(MAX_WINDOW)) ? idx : idx + 1'b1;
            issue_cnt     <= '0;
            data_vld      <= 1'b0;
            if (pass) begin
              out_valid <= 1'b1;
              state     <= sma_pkg::S_OUT;
            end else begin
              state <= sma_pkg::S_ACC;
            end
          end
        end
        sma_pkg::S_ACC: begin
          if (issuing) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          data_vld <= issuing;
          if (!issuing && !data_vld) begin
            state <= sma_pkg::S_NEG;
          end
        end
        sma_pkg::S_NEG: begin
          div_cnt <= '0;
          state   <= sma_pkg::S_DIV;
        end
        sma_pkg::S_DIV: begin
          if (div_cnt == DCW'(SW - 1)) begin
            state <= sma_pkg::S_FIX;
          end else begin
            div_cnt <= div_cnt + 1'b1;
          end
        end
        sma_pkg::S_FIX: begin
          out_valid <= 1'b1;
          state     <= sma_pkg::S_OUT;
        end
        sma_pkg::S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= sma_pkg::S_IDLE;
          end
        end
        default: begin
          state <= sma_pkg::S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      sma_pkg::S_IDLE: begin
        if (in_xfer) begin
          rd_ptr <= write_pointer;
          acc    <= '0;
          n_q    <= eff_len;
          out_data.average_value <= in_data.sample;
          out_data.is_average    <= 1'b0;
        end
      end
      sma_pkg::S_ACC: begin
        if (issuing) begin
          rd_ptr <= (rd_ptr == '0) ? AW'(MAX_WINDOW - 1) : rd_ptr - 1'b1;
        end
        if (data_vld) begin
          acc <= add_sum[SW-1:0];
        end
      end
      sma_pkg::S_NEG: begin
        neg <= acc[SW-1];
        rem <= '0;
        if (acc[SW-1]) begin
          acc <= add_sum[SW-1:0];
        end
      end
      sma_pkg::S_DIV: begin
        // restoring step: sign of the trial subtract decides the quotient bit
        acc <= {acc[SW-2:0], ~add_sum[ADW-1]};
        rem <= add_sum[ADW-1] ? rem_sh[EW-1:0] : add_sum[EW-1:0];
      end
      sma_pkg::S_FIX: begin
        out_data.average_value <= neg ? add_sum[sma_pkg::SAMPLE_W-1:0]
                                      : acc[sma_pkg::SAMPLE_W-1:0];
        out_data.is_average    <= 1'b1;
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

endmodule

/* design/sma_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/sma_checker.sv */
// Port-level checks for simple_moving_average, attached by bind.
// Depends on sma_pkg and simple_moving_average.
module sma_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input sma_pkg::out_t out_data
);

  // one item in flight: no new transfer while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready high while a result is pending");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  a_idle_after_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid && in_ready)
    else $error("block not idle after result transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind simple_moving_average sma_checker u_sma_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
